FILE: design/md5_pkg.sv
// MD5 stream hasher package: chaining-word initial values, the per-round
// sine constants, the rotation amounts and the message-word schedule.
// No dependencies.
package md5_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int BUF_ADDR_W  = $clog2(BLOCK_WORDS);

    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hefcd_ab89;
    localparam logic [31:0] IV_C = 32'h98ba_dcfe;
    localparam logic [31:0] IV_D = 32'h1032_5476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_abcd_t;

    function automatic logic [31:0] md5_k(input logic [5:0] rnd);
        case (rnd)
            6'd0:  md5_k = 32'hd76aa478;
            6'd1:  md5_k = 32'he8c7b756;
            6'd2:  md5_k = 32'h242070db;
            6'd3:  md5_k = 32'hc1bdceee;
            6'd4:  md5_k = 32'hf57c0faf;
            6'd5:  md5_k = 32'h4787c62a;
            6'd6:  md5_k = 32'ha8304613;
            6'd7:  md5_k = 32'hfd469501;
            6'd8:  md5_k = 32'h698098d8;
            6'd9:  md5_k = 32'h8b44f7af;
            6'd10: md5_k = 32'hffff5bb1;
            6'd11: md5_k = 32'h895cd7be;
            6'd12: md5_k = 32'h6b901122;
            6'd13: md5_k = 32'hfd987193;
            6'd14: md5_k = 32'ha679438e;
            6'd15: md5_k = 32'h49b40821;
            6'd16: md5_k = 32'hf61e2562;
            6'd17: md5_k = 32'hc040b340;
            6'd18: md5_k = 32'h265e5a51;
            6'd19: md5_k = 32'he9b6c7aa;
            6'd20: md5_k = 32'hd62f105d;
            6'd21: md5_k = 32'h02441453;
            6'd22: md5_k = 32'hd8a1e681;
            6'd23: md5_k = 32'he7d3fbc8;
            6'd24: md5_k = 32'h21e1cde6;
            6'd25: md5_k = 32'hc33707d6;
            6'd26: md5_k = 32'hf4d50d87;
            6'd27: md5_k = 32'h455a14ed;
            6'd28: md5_k = 32'ha9e3e905;
            6'd29: md5_k = 32'hfcefa3f8;
            6'd30: md5_k = 32'h676f02d9;
            6'd31: md5_k = 32'h8d2a4c8a;
            6'd32: md5_k = 32'hfffa3942;
            6'd33: md5_k = 32'h8771f681;
            6'd34: md5_k = 32'h6d9d6122;
            6'd35: md5_k = 32'hfde5380c;
            6'd36: md5_k = 32'ha4beea44;
            6'd37: md5_k = 32'h4bdecfa9;
            6'd38: md5_k = 32'hf6bb4b60;
            6'd39: md5_k = 32'hbebfbc70;
            6'd40: md5_k = 32'h289b7ec6;
            6'd41: md5_k = 32'heaa127fa;
            6'd42: md5_k = 32'hd4ef3085;
            6'd43: md5_k = 32'h04881d05;
            6'd44: md5_k = 32'hd9d4d039;
            6'd45: md5_k = 32'he6db99e5;
            6'd46: md5_k = 32'h1fa27cf8;
            6'd47: md5_k = 32'hc4ac5665;
            6'd48: md5_k = 32'hf4292244;
            6'd49: md5_k = 32'h432aff97;
            6'd50: md5_k = 32'hab9423a7;
            6'd51: md5_k = 32'hfc93a039;
            6'd52: md5_k = 32'h655b59c3;
            6'd53: md5_k = 32'h8f0ccc92;
            6'd54: md5_k = 32'hffeff47d;
            6'd55: md5_k = 32'h85845dd1;
            6'd56: md5_k = 32'h6fa87e4f;
            6'd57: md5_k = 32'hfe2ce6e0;
            6'd58: md5_k = 32'ha3014314;
            6'd59: md5_k = 32'h4e0811a1;
            6'd60: md5_k = 32'hf7537e82;
            6'd61: md5_k = 32'hbd3af235;
            6'd62: md5_k = 32'h2ad7d2bb;
            6'd63: md5_k = 32'heb86d391;
            default: md5_k = 32'h0;
        endcase
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
        case ({rnd[5:4], rnd[1:0]})
            4'd0:  md5_rot = 5'd7;
            4'd1:  md5_rot = 5'd12;
            4'd2:  md5_rot = 5'd17;
            4'd3:  md5_rot = 5'd22;
            4'd4:  md5_rot = 5'd5;
            4'd5:  md5_rot = 5'd9;
            4'd6:  md5_rot = 5'd14;
            4'd7:  md5_rot = 5'd20;
            4'd8:  md5_rot = 5'd4;
            4'd9:  md5_rot = 5'd11;
            4'd10: md5_rot = 5'd16;
            4'd11: md5_rot = 5'd23;
            4'd12: md5_rot = 5'd6;
            4'd13: md5_rot = 5'd10;
            4'd14: md5_rot = 5'd15;
            4'd15: md5_rot = 5'd21;
            default: md5_rot = 5'd0;
        endcase
    endfunction

    // message word used by a round
    function automatic logic [3:0] md5_g(input logic [5:0] rnd);
        logic [3:0] ri;
        ri = rnd[3:0];
        case (rnd[5:4])
            2'd0: md5_g = ri;
            2'd1: md5_g = (ri << 2) + ri + 4'd1;
            2'd2: md5_g = (ri << 1) + ri + 4'd5;
            2'd3: md5_g = (ri << 3) - ri;
            default: md5_g = ri;
        endcase
    endfunction

endpackage

FILE: design/md5_in_if.sv
// Input channel of the MD5 stream hasher: one message word per beat.
// Depends on nothing.
interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, output message_word, output byte_count,
                    output last_word, input ready);
    modport sink   (input valid, input message_word, input byte_count,
                    input last_word, output ready);
endinterface

FILE: design/md5_out_if.sv
// Output channel of the MD5 stream hasher: one digest per beat.
// Depends on nothing.
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    modport source (output valid, output digest_a, output digest_b,
                    output digest_c, output digest_d, input ready);
    modport sink   (input valid, input digest_a, input digest_b,
                    input digest_c, input digest_d, output ready);
endinterface

FILE: design/md5_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/md5_round.sv
// One MD5 round step: round function, sine constant, rotate and register
// shuffle. Depends on md5_pkg.
module md5_round
    import md5_pkg::*;
(
    input  logic [5:0]  rnd,
    input  md5_abcd_t   work,
    input  logic [31:0] msg_word,
    output md5_abcd_t   work_next
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;

    always_comb
    begin
        case (rnd[5:4])
            2'd0: f = (work.b & work.c) | (~work.b & work.d);
            2'd1: f = (work.d & work.b) | (~work.d & work.c);
            2'd2: f = work.b ^ work.c ^ work.d;
            2'd3: f = work.c ^ (work.b | ~work.d);
            default: f = '0;
        endcase
        sum      = work.a + f + md5_k(rnd) + msg_word;
        rot_wide = {sum, sum} << md5_rot(rnd);
        work_next.a = work.d;
        work_next.b = work.b + rot_wide[63:32];
        work_next.c = work.b;
        work_next.d = work.c;
    end

endmodule

FILE: design/md5_stream_hasher.sv
// MD5 stream hasher top level: byte gathering, padding sequencer and the
// compression loop around the block buffer RAM. Depends on md5_pkg,
// md5_in_if, md5_out_if, md5_ram and md5_round.
//
// A message word is taken while the hasher is idle; bytes are packed into whole
// words in a small gather register and written to a 16-word block buffer RAM.
// When a 64-byte block fills, the input stalls for a prefetch of the first
// message word, 64 rounds at one per cycle through the single round unit, fed
// by the buffer RAM's read port one word ahead, and a step that adds into the
// chaining words. The last word adds a step that writes the pad byte, a fill
// of the remaining buffer words at one per cycle, one compression (two when
// fewer than nine bytes are left for the length), and a step that moves the
// digest into the output register once that register is free; the next
// message may start while the digest waits there. The buffer needs no
// clearing after reset.
module md5_stream_hasher
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    md5_in_if.sink      msg_in,
    md5_out_if.source   digest_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_HEAD = 3'd4;
    localparam logic [2:0] ST_FILL = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [5:0]            bib_reg, bib_next;
    logic [60:0]           msg_bytes_reg, msg_bytes_next;
    logic [23:0]           partial_reg, partial_next;
    logic [5:0]            rnd_reg, rnd_next;
    logic [BUF_ADDR_W-1:0] idx_reg, idx_next;
    logic                  pad_pending_reg, pad_pending_next;
    logic                  pad_mode_reg, pad_mode_next;
    logic                  extra_reg, extra_next;
    md5_abcd_t             chain_reg, chain_next;
    md5_abcd_t             work_reg, work_next;
    md5_abcd_t             round_out;
    logic                  out_valid_reg, out_valid_next;
    md5_abcd_t             out_reg, out_next;

    logic                  ram_we;
    logic [BUF_ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [BUF_ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  accept;
    logic [2:0]            cnt;
    logic [31:0]           word_masked;
    logic [55:0]           merged;
    logic [2:0]            fill_sum;
    logic [63:0]           bit_len;
    logic                  out_free;
    logic                  partial_clean;

    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5_round u_round (
        .rnd       (rnd_reg),
        .work      (work_reg),
        .msg_word  (ram_rdata),
        .work_next (round_out)
    );

    assign msg_in.ready = (state_reg == ST_IDLE);
    assign accept       = msg_in.valid && msg_in.ready;
    assign out_free     = !out_valid_reg || digest_out.ready;
    assign bit_len      = {msg_bytes_reg, 3'b000};

    always_comb
    begin
        cnt = (msg_in.byte_count > 3'd4) ? 3'd4 : msg_in.byte_count;
        for (int k = 0; k < 4; k++)
        begin
            word_masked[8*k +: 8] = (3'(k) < cnt) ? msg_in.message_word[8*k +: 8] : 8'h00;
        end
        merged   = {32'h0, partial_reg} | ({24'h0, word_masked} << {bib_reg[1:0], 3'b000});
        fill_sum = {1'b0, bib_reg[1:0]} + cnt;
    end

    always_comb
    begin
        state_next       = state_reg;
        bib_next         = bib_reg;
        msg_bytes_next   = msg_bytes_reg;
        partial_next     = partial_reg;
        rnd_next         = rnd_reg;
        idx_next         = idx_reg;
        pad_pending_next = pad_pending_reg;
        pad_mode_next    = pad_mode_reg;
        extra_next       = extra_reg;
        chain_next       = chain_reg;
        work_next        = work_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        ram_we           = 1'b0;
        ram_waddr        = bib_reg[5:2];
        ram_wdata        = merged[31:0];
        ram_raddr        = md5_g(6'd0);

        if (digest_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bib_next       = bib_reg + {3'b000, cnt};
                    msg_bytes_next = msg_bytes_reg + {58'h0, cnt};
                    if (fill_sum[2])
                    begin
                        ram_we       = 1'b1;
                        partial_next = merged[55:32];
                    end
                    else
                    begin
                        partial_next = merged[23:0];
                    end
                    if (fill_sum[2] && (bib_reg[5:2] == BUF_ADDR_W'(BLOCK_WORDS - 1)))
                    begin
                        pad_pending_next = msg_in.last_word;
                        state_next       = ST_PRE;
                    end
                    else if (msg_in.last_word)
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end

            ST_PRE:
            begin
                work_next  = chain_reg;
                rnd_next   = 6'd0;
                state_next = ST_COMP;
            end

            ST_COMP:
            begin
                ram_raddr = md5_g(rnd_reg + 6'd1);
                work_next = round_out;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (pad_mode_reg)
                begin
                    if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        idx_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (pad_pending_reg)
                begin
                    pad_pending_next = 1'b0;
                    state_next       = ST_HEAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_HEAD:
            begin
                ram_we        = 1'b1;
                ram_wdata     = {8'h00, partial_reg}
                              | ({24'h0, PAD_BYTE} << {bib_reg[1:0], 3'b000});
                pad_mode_next = 1'b1;
                extra_next    = (bib_reg[5:3] == 3'b111);
                idx_next      = bib_reg[5:2] + 4'd1;
                if (bib_reg[5:2] == BUF_ADDR_W'(BLOCK_WORDS - 1))
                begin
                    state_next = ST_PRE;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if ((idx_reg >= BUF_ADDR_W'(BLOCK_WORDS - 2)) && !extra_reg)
                begin
                    ram_wdata = idx_reg[0] ? bit_len[63:32] : bit_len[31:0];
                end
                else
                begin
                    ram_wdata = '0;
                end
                idx_next = idx_reg + 4'd1;
                if (idx_reg == BUF_ADDR_W'(BLOCK_WORDS - 1))
                begin
                    state_next = ST_PRE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = chain_reg;
                    out_valid_next = 1'b1;
                    chain_next     = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
                    bib_next       = '0;
                    msg_bytes_next = '0;
                    partial_next   = '0;
                    pad_mode_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bib_reg         <= '0;
            msg_bytes_reg   <= '0;
            partial_reg     <= '0;
            rnd_reg         <= '0;
            idx_reg         <= '0;
            pad_pending_reg <= 1'b0;
            pad_mode_reg    <= 1'b0;
            extra_reg       <= 1'b0;
            chain_reg       <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bib_reg         <= bib_next;
            msg_bytes_reg   <= msg_bytes_next;
            partial_reg     <= partial_next;
            rnd_reg         <= rnd_next;
            idx_reg         <= idx_next;
            pad_pending_reg <= pad_pending_next;
            pad_mode_reg    <= pad_mode_next;
            extra_reg       <= extra_next;
            chain_reg       <= chain_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign digest_out.valid    = out_valid_reg;
    assign digest_out.digest_a = out_reg.a;
    assign digest_out.digest_b = out_reg.b;
    assign digest_out.digest_c = out_reg.c;
    assign digest_out.digest_d = out_reg.d;

    assign partial_clean =
        ((partial_reg & ~24'((32'h1 << {bib_reg[1:0], 3'b000}) - 32'h1)) == 24'h0);

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> !ram_we)
    else $error("block buffer written during compression");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    else $error("digest beat raised outside the final step");

    assert property (@(posedge clk) disable iff (!rst_n)
        partial_clean)
    else $error("gather register holds bytes beyond the fill level");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (bib_reg == 6'd0 && msg_bytes_reg == 61'h0))
    else $error("byte counters not cleared after digest");

endmodule

FILE: tb/tb_top.sv
// Testbench for md5_stream_hasher: directed and random message streams, with
// every digest checked against an RFC 1321 MD5 predictor held in this file.
// Depends on md5_in_if, md5_out_if and md5_stream_hasher (with md5_pkg).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 750;
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } word_beat_t;

    typedef logic [3:0][31:0] digest_t;

    logic clk = 1'b0;
    logic rst_n;

    md5_in_if  msg_bus();
    md5_out_if digest_bus();

    md5_stream_hasher u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_bus),
        .digest_out (digest_bus)
    );

    word_beat_t  words_pending [$];
    digest_t     digests_due [$];
    int unsigned total_words = 0;
    int unsigned words_taken = 0;
    int unsigned real_items  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    logic        hold_off;

    logic [31:0] sine_k [64];
    int unsigned rot_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] chain_q [4];
    logic [7:0]  block_q [64];
    int unsigned fill_q;
    logic [60:0] msg_len_q;

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic restart_message();
        chain_q[0] = 32'h6745_2301;
        chain_q[1] = 32'hefcd_ab89;
        chain_q[2] = 32'h98ba_dcfe;
        chain_q[3] = 32'h1032_5476;
        fill_q     = 0;
        msg_len_q  = '0;
    endtask

    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t, m;
        int unsigned g;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int unsigned i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            m = {block_q[4 * g + 3], block_q[4 * g + 2], block_q[4 * g + 1], block_q[4 * g]};
            t = d;
            d = c;
            c = b;
            b = b + rotl(a + f + sine_k[i] + m, rot_amt[(i / 16) * 4 + i % 4]);
            a = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
    endtask

    task automatic absorb_word(logic [31:0] word, logic [2:0] count, logic last);
        int unsigned n;
        logic [63:0] bit_len;
        n = (count > 3'd4) ? 4 : count;
        for (int unsigned k = 0; k < n; k++) begin
            block_q[fill_q] = word[8 * k +: 8];
            fill_q = (fill_q + 1) % 64;
            msg_len_q = msg_len_q + 1'b1;
            if (fill_q == 0)
                compress_block();
        end
        if (last) begin
            block_q[fill_q] = 8'h80;
            fill_q = fill_q + 1;
            if (fill_q > 56) begin
                while (fill_q < 64) begin
                    block_q[fill_q] = 8'h00;
                    fill_q = fill_q + 1;
                end
                compress_block();
                fill_q = 0;
            end
            while (fill_q < 56) begin
                block_q[fill_q] = 8'h00;
                fill_q = fill_q + 1;
            end
            bit_len = {msg_len_q, 3'b000};
            for (int unsigned k = 0; k < 8; k++)
                block_q[56 + k] = bit_len[8 * k +: 8];
            compress_block();
            digests_due.push_back({chain_q[3], chain_q[2], chain_q[1], chain_q[0]});
            restart_message();
        end
    endtask

    task automatic queue_beat(logic [31:0] word, logic [2:0] count, logic last);
        words_pending.push_back('{word: word, count: count, last: last});
        if (count != 3'd0 || last)
            real_items++;
    endtask

    always @(posedge clk or negedge rst_n) begin : word_driver
        word_beat_t nxt;
        int unsigned idle_pct;
        if (!rst_n) begin
            msg_bus.valid        <= 1'b0;
            msg_bus.message_word <= '0;
            msg_bus.byte_count   <= '0;
            msg_bus.last_word    <= 1'b0;
            words_taken          <= 0;
            restart_message();
        end
        else begin
            if (msg_bus.valid && msg_bus.ready) begin
                absorb_word(msg_bus.message_word, msg_bus.byte_count, msg_bus.last_word);
                words_taken <= words_taken + 1;
            end
            if (words_taken < total_words / 3)
                idle_pct = 10;
            else if (words_taken < (2 * total_words) / 3)
                idle_pct = 46;
            else
                idle_pct = 0;
            if (!msg_bus.valid || msg_bus.ready) begin
                if (words_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = words_pending.pop_front();
                    msg_bus.valid        <= 1'b1;
                    msg_bus.message_word <= nxt.word;
                    msg_bus.byte_count   <= nxt.count;
                    msg_bus.last_word    <= nxt.last;
                end
                else begin
                    msg_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : digest_monitor
        digest_t got;
        digest_t want;
        int unsigned idle_pct;
        if (!rst_n) begin
            digest_bus.ready <= 1'b0;
        end
        else begin
            if (digest_bus.valid && digest_bus.ready) begin
                got = {digest_bus.digest_d, digest_bus.digest_c,
                       digest_bus.digest_b, digest_bus.digest_a};
                if (digests_due.size() == 0) begin
                    $display("%0t: digest %h with none expected", $time, got);
                    mismatches++;
                end
                else begin
                    want = digests_due.pop_front();
                    for (int unsigned i = 0; i < 4; i++) begin
                        if (got[i] !== want[i]) begin
                            $display("%0t: digest_%c expected %08h, got %08h",
                                     $time, 8'h61 + i, want[i], got[i]);
                            mismatches++;
                        end
                    end
                end
            end
            if (words_taken < total_words / 3)
                idle_pct = 46;
            else if (words_taken < (2 * total_words) / 3)
                idle_pct = 10;
            else
                idle_pct = 0;
            digest_bus.ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin : receiver_hold
        hold_off = 1'b0;
        @(posedge rst_n);
        while (words_taken < (2 * total_words) / 3)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        real         s;
        int unsigned len, left, take, pick;
        logic [2:0]  cnt;
        rst_n = 1'b0;

        for (int i = 0; i < 64; i++) begin
            s = $sin(i + 1.0);
            if (s < 0.0)
                s = -s;
            s = $floor(s * 4294967296.0);
            sine_k[i] = 32'(longint'(s));
        end

        queue_beat(32'hffff_ffff, 3'd0, 1'b1);
        queue_beat(32'h0063_6261, 3'd3, 1'b1);
        queue_beat(32'hffff_ffff, 3'd7, 1'b1);
        queue_beat(32'hffff_ffff, 3'd0, 1'b0);
        queue_beat(32'h1234_5678, 3'd2, 1'b0);
        queue_beat(32'h0000_0000, 3'd4, 1'b0);
        queue_beat(32'hffff_ffff, 3'd6, 1'b0);
        queue_beat(32'ha5a5_a5a5, 3'd1, 1'b1);
        // 56 bytes: the length no longer fits, so padding spills into a second block
        for (int i = 0; i < 14; i++)
            queue_beat(32'hffff_ffff, 3'd4, i == 13);
        queue_beat(32'h0000_0000, 3'd5, 1'b1);

        real_items = 0;
        while (real_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                len = $urandom_range(0, 40);
            else if (pick < 16)
                len = $urandom_range(52, 72);
            else if (pick < 19)
                len = $urandom_range(0, 150);
            else
                len = $urandom_range(180, 260);
            left = len;
            while (left > 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    cnt  = 3'd0;
                    take = 0;
                end
                else if (pick < 10) begin
                    cnt  = 3'($urandom_range(1, 3));
                    take = 32'(cnt);
                end
                else if (pick < 16) begin
                    cnt  = 3'($urandom_range(5, 7));
                    take = 4;
                end
                else begin
                    cnt  = 3'd4;
                    take = 4;
                end
                queue_beat($urandom(), cnt, 1'b0);
                left -= take;
            end
            if (left == 4 && $urandom_range(0, 9) == 0) begin
                queue_beat($urandom(), 3'd4, 1'b0);
                left = 0;
            end
            cnt = 3'(left);
            if (left == 4 && $urandom_range(0, 3) == 0)
                cnt = 3'($urandom_range(5, 7));
            queue_beat($urandom(), cnt, 1'b1);
        end
        total_words = words_pending.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_pending.size() != 0 || msg_bus.valid || digests_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: md5_stream_hasher.f
design/md5_pkg.sv
design/md5_in_if.sv
design/md5_out_if.sv
design/md5_ram.sv
design/md5_round.sv
design/md5_stream_hasher.sv
tb/tb_top.sv
